// File: hdl/mtlr_pkg.sv
// Package for the multi-timer lap recorder: field widths, command, status and
// result kind codes, configuration register indexes, and controller/datapath structs.
// No dependencies.
package mtlr_pkg;

  // Field widths
  localparam int CMD_W         = 2;
  localparam int TIMER_ID_W    = 8;
  localparam int TIME_W        = 32;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int LAP_NUM_W     = 4;
  localparam int TIMER_COUNT_W = 3;
  localparam int LAP_LIMIT_W   = 5;
  localparam int CFG_DATA_W    = 5;
  localparam int CFG_IDX_W     = 1;

  // Parameter defaults
  localparam int NUM_TIMERS_DEF = 4;
  localparam int MAX_LAPS_DEF   = 16;

  // Configuration reset values
  localparam logic [TIMER_COUNT_W-1:0] TIMER_COUNT_RST = 3'd3;
  localparam logic [LAP_LIMIT_W-1:0]   LAP_LIMIT_RST   = 5'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAP_LIMIT   = 1'b1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SHOW  = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELAPSED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LAP     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOTAL   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_ID  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_STOPPED = 2'd2;
  localparam logic [STATUS_W-1:0] STS_WRAPPED = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the incoming transaction
    logic exec;        // decode, update timer state, maybe emit a status result
    logic k_clr;       // restart the lap read pointer
    logic emit_lap;    // emit the lap at the read pointer and advance it
    logic emit_total;  // emit the total time
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic exec_emits;  // the command finishes with one status result
    logic single;      // show has exactly one lap stored
    logic last_lap;    // read pointer is at the final stored lap
  } dp_sts_t;

endpackage

// File: hdl/mtlr_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on mtlr_pkg for field widths.
interface mtlr_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [mtlr_pkg::CMD_W-1:0]         cmd;
  logic [mtlr_pkg::TIMER_ID_W-1:0]    timer_id;
  logic [mtlr_pkg::TIME_W-1:0]        now_us;

  modport source (output valid, cmd, timer_id, now_us, input ready);
  modport sink   (input valid, cmd, timer_id, now_us, output ready);
endinterface

interface mtlr_res_if;
  logic                               valid;
  logic                               ready;
  logic [mtlr_pkg::KIND_W-1:0]        kind;
  logic [mtlr_pkg::STATUS_W-1:0]      status;
  logic [mtlr_pkg::LAP_NUM_W-1:0]     lap_number;
  logic [mtlr_pkg::TIME_W-1:0]        duration_us;
  logic                               last;

  modport source (output valid, kind, status, lap_number, duration_us, last, input ready);
  modport sink   (input valid, kind, status, lap_number, duration_us, last, output ready);
endinterface

// File: hdl/mtlr_ctrl.sv
// Controller state machine of the lap recorder: sequences capture, execute,
// lap streaming and total emission. Depends on mtlr_pkg.
module mtlr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtlr_pkg::dp_sts_t  sts_i,
  output mtlr_pkg::ctl_cmd_t ctl_o
);
  import mtlr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_LAPS  = 3'd3;
  localparam logic [2:0] S_TOTAL = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    ctl_o            = '0;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = sts_i.exec_emits ? S_IDLE : S_PREP;
        end
      end
      S_PREP: begin
        // prep state so the first lap read sees a lap written during execute
        ctl_o.k_clr = 1'b1;
        state_d     = S_LAPS;
      end
      S_LAPS: begin
        if (sts_i.out_free) begin
          ctl_o.emit_lap = 1'b1;
          if (sts_i.single) begin
            state_d = S_IDLE;
          end else if (sts_i.last_lap) begin
            state_d = S_TOTAL;
          end
        end
      end
      S_TOTAL: begin
        if (sts_i.out_free) begin
          ctl_o.emit_total = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/mtlr_datapath.sv
// Datapath of the lap recorder: configuration registers, per-timer state,
// lap duration memory, lap read pointer and the result register. Depends on mtlr_pkg.
module mtlr_datapath #(
  parameter int NUM_TIMERS = mtlr_pkg::NUM_TIMERS_DEF,
  parameter int MAX_LAPS   = mtlr_pkg::MAX_LAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mtlr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mtlr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [mtlr_pkg::CMD_W-1:0]          cmd_i,
  input  logic [mtlr_pkg::TIMER_ID_W-1:0]     timer_id_i,
  input  logic [mtlr_pkg::TIME_W-1:0]         now_us_i,
  input  mtlr_pkg::ctl_cmd_t                  ctl_i,
  output mtlr_pkg::dp_sts_t                   sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mtlr_pkg::KIND_W-1:0]         kind_o,
  output logic [mtlr_pkg::STATUS_W-1:0]       status_o,
  output logic [mtlr_pkg::LAP_NUM_W-1:0]      lap_number_o,
  output logic [mtlr_pkg::TIME_W-1:0]         duration_us_o,
  output logic                                last_o
);
  import mtlr_pkg::*;

  localparam int TidW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int LidxW    = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;
  localparam int LimW     = ($clog2(MAX_LAPS + 1) > LAP_LIMIT_W) ? $clog2(MAX_LAPS + 1)
                                                                 : LAP_LIMIT_W;
  localparam int MemDepth = 1 << (TidW + LidxW);

  // Configuration
  logic [TIMER_COUNT_W-1:0] timer_count_q;
  logic [LAP_LIMIT_W-1:0]   lap_limit_q;

  // Captured transaction
  logic [CMD_W-1:0]      cmd_q;
  logic [TIMER_ID_W-1:0] tid_q;
  logic [TIME_W-1:0]     now_q;

  // Per-timer state
  logic [NUM_TIMERS-1:0] running_q;
  logic [LidxW-1:0]      lidx_q       [NUM_TIMERS];
  logic [TIME_W-1:0]     lap_start_q  [NUM_TIMERS];
  logic [TIME_W-1:0]     start_time_q [NUM_TIMERS];

  // Lap memory and read side
  logic [TIME_W-1:0] mem_q [MemDepth];
  logic [TIME_W-1:0] rdata_q;
  logic [LidxW-1:0]  k_q, k_d;
  logic [LidxW-1:0]  cur_q;

  // Result register
  logic                 ovalid_q;
  logic [KIND_W-1:0]    kind_q;
  logic [STATUS_W-1:0]  status_q;
  logic [LAP_NUM_W-1:0] lapno_q;
  logic [TIME_W-1:0]    dur_q;
  logic                 last_q;

  // Decode signals
  logic [TIMER_ID_W-1:0] tc_ext, nt_ext, cnt;
  logic                  bad;
  logic [TidW-1:0]       id;
  logic                  sel_run;
  logic [LidxW-1:0]      sel_idx, idx_c, idx_new, cur_new;
  logic [TIME_W-1:0]     sel_lstart, sel_start, lap_dur, total_dur;
  logic [LimW-1:0]       lim_ext, eff_lim, idx_inc, k_ext;
  logic                  wrap, show_lap, do_lap, exec_emits;
  logic [STATUS_W-1:0]   lap_sts, exec_sts;
  logic                  load;
  logic [TidW+LidxW-1:0] wr_addr, rd_addr;

  // Resolve the addressed timer against the clamped timer count
  assign tc_ext = TIMER_ID_W'(timer_count_q);
  assign nt_ext = TIMER_ID_W'(NUM_TIMERS);
  assign cnt    = (tc_ext > nt_ext) ? nt_ext : tc_ext;
  assign bad    = (tid_q >= cnt);
  assign id     = tid_q[TidW-1:0];

  assign sel_run    = running_q[id];
  assign sel_idx    = lidx_q[id];
  assign sel_lstart = lap_start_q[id];
  assign sel_start  = start_time_q[id];

  // Clamp the lap limit into 1..MAX_LAPS
  always_comb begin
    lim_ext = LimW'(lap_limit_q);
    if (lim_ext == '0) begin
      eff_lim = LimW'(1);
    end else if (lim_ext > LimW'(MAX_LAPS)) begin
      eff_lim = LimW'(MAX_LAPS);
    end else begin
      eff_lim = lim_ext;
    end
  end

  // Take a lap: next index, wrap and duration
  assign idx_c     = (LimW'(sel_idx) >= LimW'(MAX_LAPS)) ? '0 : sel_idx;
  assign idx_inc   = LimW'(idx_c) + LimW'(1);
  assign wrap      = (idx_inc >= eff_lim);
  assign idx_new   = wrap ? '0 : idx_inc[LidxW-1:0];
  assign lap_dur   = now_q - sel_lstart;
  assign total_dur = now_q - sel_start;
  assign lap_sts   = wrap ? STS_WRAPPED : STS_OK;

  assign show_lap = (cmd_q == CMD_SHOW) && (sel_idx == '0);
  assign cur_new  = show_lap ? idx_new : sel_idx;
  assign do_lap   = !bad && sel_run &&
                    ((cmd_q == CMD_LAP) || (cmd_q == CMD_END) || show_lap);

  assign exec_emits = bad || (cmd_q != CMD_SHOW) || !sel_run || (cur_new == '0);

  // Status of a single-result command
  always_comb begin
    priority if (bad) begin
      exec_sts = STS_BAD_ID;
    end else if (cmd_q == CMD_START) begin
      exec_sts = STS_OK;
    end else if (!sel_run) begin
      exec_sts = STS_STOPPED;
    end else if (cmd_q == CMD_SHOW) begin
      exec_sts = show_lap ? lap_sts : STS_OK;
    end else begin
      exec_sts = lap_sts;
    end
  end

  // Status to the controller
  assign sts_o.out_free   = !ovalid_q || out_ready_i;
  assign sts_o.exec_emits = exec_emits;
  assign sts_o.single     = (cur_q == LidxW'(1));
  assign sts_o.last_lap   = ((LimW'(k_q) + LimW'(1)) == LimW'(cur_q));

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_count_q <= TIMER_COUNT_RST;
      lap_limit_q   <= LAP_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TIMER_COUNT) begin
        timer_count_q <= cfg_data_i[TIMER_COUNT_W-1:0];
      end else if (cfg_idx_i == REG_LAP_LIMIT) begin
        lap_limit_q <= cfg_data_i[LAP_LIMIT_W-1:0];
      end
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= cmd_i;
      tid_q <= timer_id_i;
      now_q <= now_us_i;
    end
  end

  // Update timer state on execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      cur_q     <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        lidx_q[t]       <= '0;
        lap_start_q[t]  <= '0;
        start_time_q[t] <= '0;
      end
    end else if (ctl_i.exec) begin
      cur_q <= cur_new;
      if (!bad) begin
        if (cmd_q == CMD_START) begin
          lap_start_q[id]  <= now_q;
          start_time_q[id] <= now_q;
          lidx_q[id]       <= '0;
          running_q[id]    <= 1'b1;
        end else if (sel_run) begin
          if (do_lap) begin
            lap_start_q[id] <= now_q;
            lidx_q[id]      <= idx_new;
          end
          if (cmd_q == CMD_END) begin
            running_q[id] <= 1'b0;
          end
        end
      end
    end
  end

  // Lap read pointer: the memory reads at the next pointer value
  always_comb begin
    k_d = k_q;
    if (ctl_i.k_clr) begin
      k_d = '0;
    end else if (ctl_i.emit_lap) begin
      k_d = k_q + LidxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  // Lap duration memory, one write and one registered read port
  assign wr_addr = {id, idx_c};
  assign rd_addr = {id, k_d};

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && do_lap) begin
      mem_q[wr_addr] <= lap_dur;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Result register
  assign load  = (ctl_i.exec && exec_emits) || ctl_i.emit_lap || ctl_i.emit_total;
  assign k_ext = LimW'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_lap) begin
      kind_q   <= sts_o.single ? KIND_ELAPSED : KIND_LAP;
      status_q <= STS_OK;
      lapno_q  <= sts_o.single ? '0 : k_ext[LAP_NUM_W-1:0];
      dur_q    <= rdata_q;
      last_q   <= sts_o.single;
    end else if (ctl_i.emit_total) begin
      kind_q   <= KIND_TOTAL;
      status_q <= STS_OK;
      lapno_q  <= '0;
      dur_q    <= total_dur;
      last_q   <= 1'b1;
    end else if (ctl_i.exec && exec_emits) begin
      kind_q   <= KIND_STATUS;
      status_q <= exec_sts;
      lapno_q  <= '0;
      dur_q    <= '0;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = kind_q;
  assign status_o      = status_q;
  assign lap_number_o  = lapno_q;
  assign duration_us_o = dur_q;
  assign last_o        = last_q;

endmodule

// File: hdl/multi_timer_lap_recorder_top.sv
// Sequencing: a start, lap or end transaction is captured on acceptance and executed
// once the result register is free, loading its result; only then is the next one taken.
// Show with one stored lap emits a single elapsed result; with n stored laps (n > 1) it
// passes a prep state, then emits the n laps and the total, stalling while output is full.
// Reset (rst_ni, async low): all timers stopped, lap indexes and times zero,
// timer_count 3, lap_limit 10; lap memory contents are left undefined.
module multi_timer_lap_recorder_top #(
  parameter int NUM_TIMERS = mtlr_pkg::NUM_TIMERS_DEF,
  parameter int MAX_LAPS   = mtlr_pkg::MAX_LAPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mtlr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mtlr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mtlr_cmd_if.sink                        cmd_i,
  mtlr_res_if.source                      res_o
);
  import mtlr_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  // Sequence each command
  mtlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Timer state, lap memory and result register
  mtlr_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .MAX_LAPS   (MAX_LAPS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i.cmd),
    .timer_id_i    (cmd_i.timer_id),
    .now_us_i      (cmd_i.now_us),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .kind_o        (res_o.kind),
    .status_o      (res_o.status),
    .lap_number_o  (res_o.lap_number),
    .duration_us_o (res_o.duration_us),
    .last_o        (res_o.last)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for multi_timer_lap_recorder_top: directed and random commands
// drive the lap recorder and results are scored against an in-bench stopwatch model.
// Depends on mtlr_pkg, the mtlr_cmd_if/mtlr_res_if interfaces and the recorder RTL.
`timescale 1ns / 100ps

module testbench;
  import mtlr_pkg::*;

  localparam int NTIM           = NUM_TIMERS_DEF;
  localparam int NLAPS          = MAX_LAPS_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic [1:0] {OP_CMD, OP_CFG, OP_PAUSE} stim_op_e;

  typedef struct {
    stim_op_e                 op;
    logic [CMD_W-1:0]         cmd;
    logic [TIMER_ID_W-1:0]    tid;
    logic [TIME_W-1:0]        now;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_data;
  } stim_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [STATUS_W-1:0]  status;
    logic [LAP_NUM_W-1:0] lap_no;
    logic [TIME_W-1:0]    dur;
    logic                 last;
  } timer_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mtlr_cmd_if cmd_bus ();
  mtlr_res_if res_bus ();

  multi_timer_lap_recorder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_bus),
    .res_o      (res_bus)
  );

  always #5 clk_i = ~clk_i;

  stim_item_t    stim_q[$];
  timer_result_t pending_results[$];
  int            mismatches = 0;

  // Stopwatch model state and register shadows
  logic [TIMER_COUNT_W-1:0] timer_count_sh;
  logic [LAP_LIMIT_W-1:0]   lap_limit_sh;
  logic                     running_sh [NTIM];
  logic [LAP_NUM_W-1:0]     lap_idx_sh [NTIM];
  logic [TIME_W-1:0]        lap_t0_sh  [NTIM];
  logic [TIME_W-1:0]        run_t0_sh  [NTIM];
  logic [TIME_W-1:0]        lap_mem_sh [NTIM][NLAPS];

  function automatic int eff_lap_limit(logic [LAP_LIMIT_W-1:0] lim);
    if (lim == 0) return 1;
    if (lim > NLAPS) return NLAPS;
    return lim;
  endfunction

  function automatic int eff_timer_count(logic [TIMER_COUNT_W-1:0] cnt);
    return (cnt > NTIM) ? NTIM : cnt;
  endfunction

  // Store one lap duration and advance the index; wrap reports STS_WRAPPED
  function automatic logic [STATUS_W-1:0] record_lap(int id, logic [TIME_W-1:0] now);
    int slot;
    slot = lap_idx_sh[id];
    if (slot >= NLAPS) slot = 0;
    lap_mem_sh[id][slot] = now - lap_t0_sh[id];
    lap_t0_sh[id] = now;
    slot++;
    if (slot >= eff_lap_limit(lap_limit_sh)) begin
      lap_idx_sh[id] = '0;
      return STS_WRAPPED;
    end
    lap_idx_sh[id] = LAP_NUM_W'(slot);
    return STS_OK;
  endfunction

  // Update timer state for one accepted command and queue its results
  task automatic predict_timer_cmd(logic [CMD_W-1:0] cmd, logic [TIMER_ID_W-1:0] tid,
                                   logic [TIME_W-1:0] now);
    timer_result_t batch[$];
    logic [STATUS_W-1:0] st;
    int id;
    int laps;
    st = STS_OK;
    id = tid;
    if (tid >= eff_timer_count(timer_count_sh)) begin
      batch.push_back('{KIND_STATUS, STS_BAD_ID, '0, '0, 1'b0});
    end else if (cmd == CMD_START) begin
      lap_t0_sh[id]  = now;
      run_t0_sh[id]  = now;
      lap_idx_sh[id] = '0;
      running_sh[id] = 1'b1;
      batch.push_back('{KIND_STATUS, STS_OK, '0, '0, 1'b0});
    end else if (!running_sh[id]) begin
      batch.push_back('{KIND_STATUS, STS_STOPPED, '0, '0, 1'b0});
    end else if (cmd == CMD_LAP) begin
      st = record_lap(id, now);
      batch.push_back('{KIND_STATUS, st, '0, '0, 1'b0});
    end else if (cmd == CMD_END) begin
      st = record_lap(id, now);
      running_sh[id] = 1'b0;
      batch.push_back('{KIND_STATUS, st, '0, '0, 1'b0});
    end else begin
      // Show takes an implicit lap when none is stored
      if (lap_idx_sh[id] == 0) st = record_lap(id, now);
      laps = lap_idx_sh[id];
      if (laps == 0) begin
        batch.push_back('{KIND_STATUS, st, '0, '0, 1'b0});
      end else if (laps == 1) begin
        batch.push_back('{KIND_ELAPSED, STS_OK, '0, lap_mem_sh[id][0], 1'b0});
      end else begin
        for (int k = 0; k < laps; k++)
          batch.push_back('{KIND_LAP, STS_OK, LAP_NUM_W'(k), lap_mem_sh[id][k], 1'b0});
        batch.push_back('{KIND_TOTAL, STS_OK, '0, now - run_t0_sh[id], 1'b0});
      end
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [TIMER_ID_W-1:0] tid,
                          logic [TIME_W-1:0] now);
    stim_item_t it;
    it.op = OP_CMD;
    it.cmd = cmd;
    it.tid = tid;
    it.now = now;
    it.reg_idx = '0;
    it.reg_data = '0;
    stim_q.push_back(it);
  endtask

  task automatic push_ctrl(stim_op_e op, logic [CFG_IDX_W-1:0] idx,
                           logic [CFG_DATA_W-1:0] data);
    stim_item_t it;
    it.op = op;
    it.cmd = '0;
    it.tid = '0;
    it.now = '0;
    it.reg_idx = idx;
    it.reg_data = data;
    stim_q.push_back(it);
  endtask

  function automatic void cmp_field(string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Command driver: one transaction at a time, config writes only when drained
  int  gap_left    = 0;
  int  settle_left = 0;
  bit  drv_burst   = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    logic nxt_we;
    stim_item_t it;
    if (!rst_ni) begin
      cmd_bus.valid    <= 1'b0;
      cmd_bus.cmd      <= '0;
      cmd_bus.timer_id <= '0;
      cmd_bus.now_us   <= '0;
      cfg_we_i         <= 1'b0;
      cfg_idx_i        <= '0;
      cfg_data_i       <= '0;
    end else begin
      nxt_valid = cmd_bus.valid;
      nxt_we    = 1'b0;
      if (cmd_bus.valid && cmd_bus.ready) begin
        predict_timer_cmd(cmd_bus.cmd, cmd_bus.timer_id, cmd_bus.now_us);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        // Hold the settle count until every result is back
        if (pending_results.size() != 0) settle_left = SETTLE_CYCLES;
        else if (settle_left != 0) settle_left--;
        if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          it = stim_q[0];
          if (it.op == OP_CMD) begin
            cmd_bus.cmd      <= it.cmd;
            cmd_bus.timer_id <= it.tid;
            cmd_bus.now_us   <= it.now;
            nxt_valid = 1'b1;
            void'(stim_q.pop_front());
            if ($urandom_range(0, 31) == 0) drv_burst = !drv_burst;
            gap_left = drv_burst ? 0 : $urandom_range(0, 15);
          end else if (pending_results.size() == 0 && settle_left == 0) begin
            if (it.op == OP_CFG) begin
              cfg_idx_i  <= it.reg_idx;
              cfg_data_i <= it.reg_data;
              nxt_we = 1'b1;
              if (it.reg_idx == REG_TIMER_COUNT) timer_count_sh = it.reg_data[TIMER_COUNT_W-1:0];
              else lap_limit_sh = it.reg_data[LAP_LIMIT_W-1:0];
            end
            void'(stim_q.pop_front());
          end
        end
      end
      cmd_bus.valid <= nxt_valid;
      cfg_we_i      <= nxt_we;
    end
  end

  // Result monitor: random backpressure, score each transaction in order
  int stall_left = 0;
  bit mon_burst  = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got = '{res_bus.kind, res_bus.status, res_bus.lap_number, res_bus.duration_us,
                res_bus.last};
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0d status %0d dur %0h",
                   $time, got.kind, got.status, got.dur);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("kind", want.kind, got.kind);
          cmp_field("status", want.status, got.status);
          cmp_field("lap_number", want.lap_no, got.lap_no);
          cmp_field("duration_us", want.dur, got.dur);
          cmp_field("last", want.last, got.last);
        end
        if ($urandom_range(0, 31) == 0) mon_burst = !mon_burst;
        stall_left = mon_burst ? 0 : $urandom_range(0, 15);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      res_bus.ready <= (stall_left == 0);
    end
  end

  // Watchdog: abort when no transaction or register write moves for too long
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("multi_timer_lap_recorder_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run
  int tc_plan [8] = '{4, 4, 2, 7, 4, 1, 5, 4};
  int ll_plan [8] = '{16, 4, 1, 0, 31, 16, 7, 12};

  initial begin
    logic [TIME_W-1:0] clk_us;
    int phase_items;
    int eff_tc;
    int eff_ll;
    int id;
    int n_laps;
    bit pause_done;

    timer_count_sh = TIMER_COUNT_RST;
    lap_limit_sh   = LAP_LIMIT_RST;
    for (int t = 0; t < NTIM; t++) begin
      running_sh[t] = 1'b0;
      lap_idx_sh[t] = '0;
      lap_t0_sh[t]  = '0;
      run_t0_sh[t]  = '0;
      for (int k = 0; k < NLAPS; k++) lap_mem_sh[t][k] = '0;
    end

    // Directed: stopped timers, bad ids, time wrap, single and multi-lap show
    push_cmd(CMD_LAP,   8'd0,   32'd50);
    push_cmd(CMD_SHOW,  8'd0,   32'd60);
    push_cmd(CMD_END,   8'd0,   32'd70);
    push_cmd(CMD_START, 8'd3,   32'd80);
    push_cmd(CMD_START, 8'd255, 32'hFFFF_FFFF);
    push_cmd(CMD_START, 8'd0,   32'hFFFF_FF00);
    push_cmd(CMD_LAP,   8'd0,   32'h0000_0010);
    push_cmd(CMD_LAP,   8'd0,   32'h0000_0400);
    push_cmd(CMD_SHOW,  8'd0,   32'h0000_0500);
    push_cmd(CMD_START, 8'd1,   32'hFFFF_FFFF);
    push_cmd(CMD_SHOW,  8'd1,   32'h0000_0007);
    push_cmd(CMD_END,   8'd1,   32'h0000_0020);
    push_cmd(CMD_SHOW,  8'd1,   32'h0000_0030);
    push_cmd(CMD_START, 8'd0,   32'h0000_1000);
    push_cmd(CMD_END,   8'd0,   32'h0000_2000);
    push_cmd(CMD_START, 8'd2,   32'h5555_5555);
    push_cmd(CMD_LAP,   8'd2,   32'h5555_6000);
    push_cmd(CMD_LAP,   8'd2,   32'h5556_0000);
    push_cmd(CMD_LAP,   8'd2,   32'h8000_0000);
    // Zero timers: every id is out of range
    push_ctrl(OP_CFG, REG_TIMER_COUNT, 5'b11000);
    push_ctrl(OP_CFG, REG_LAP_LIMIT, 5'd1);
    push_cmd(CMD_START, 8'd0,   32'h0000_3000);
    // Count above the bank acts as the full bank; index left above a lowered limit
    push_ctrl(OP_CFG, REG_TIMER_COUNT, 5'b00111);
    push_cmd(CMD_SHOW,  8'd2,   32'h9000_0000);
    push_cmd(CMD_LAP,   8'd2,   32'hA000_0000);
    push_cmd(CMD_START, 8'd3,   32'hAAAA_AAAA);
    push_cmd(CMD_LAP,   8'd3,   32'hAAAA_BBBB);
    push_cmd(CMD_SHOW,  8'd3,   32'hAAAA_CCCC);
    push_cmd(CMD_END,   8'd3,   32'hAAAA_DDDD);

    // Random phases: mostly start/lap/show/end sequences, some noise
    clk_us = 32'hFFF0_0000;
    pause_done = 1'b0;
    for (int p = 0; p < 8; p++) begin
      push_ctrl(OP_CFG, REG_TIMER_COUNT, {2'($urandom_range(0, 3)), 3'(tc_plan[p])});
      push_ctrl(OP_CFG, REG_LAP_LIMIT, 5'(ll_plan[p]));
      eff_tc = eff_timer_count(3'(tc_plan[p]));
      eff_ll = eff_lap_limit(5'(ll_plan[p]));
      phase_items = 0;
      while (phase_items < 45) begin
        if (p == 2 && phase_items > 20 && !pause_done) begin
          push_ctrl(OP_PAUSE, '0, '0);
          pause_done = 1'b1;
        end
        clk_us += ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(1, 3000);
        if ($urandom_range(0, 99) < 25) begin
          push_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom());
          phase_items++;
        end else begin
          id = $urandom_range(0, eff_tc - 1);
          n_laps = $urandom_range(0, eff_ll + 2);
          push_cmd(CMD_START, 8'(id), clk_us);
          for (int k = 0; k < n_laps; k++) begin
            clk_us += $urandom_range(0, 5000);
            push_cmd(($urandom_range(0, 4) == 0) ? CMD_SHOW : CMD_LAP, 8'(id), clk_us);
          end
          clk_us += $urandom_range(0, 5000);
          push_cmd(CMD_SHOW, 8'(id), clk_us);
          phase_items += n_laps + 2;
          if ($urandom_range(0, 1) == 1) begin
            clk_us += $urandom_range(0, 5000);
            push_cmd(CMD_END, 8'(id), clk_us);
            phase_items++;
          end
        end
      end
    end

    // Release reset once the stimulus is queued
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all stimulus to go out and every result to come back
    do @(negedge clk_i);
    while (stim_q.size() != 0 || cmd_bus.valid || pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results still expected at end of run", $time,
               pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("multi_timer_lap_recorder_top regression: pass");
    end else begin
      $display("multi_timer_lap_recorder_top regression: fail");
    end
    $finish;
  end

endmodule
